@@ hdl/ckblit_pkg.sv @@
// Package: shared types, constants and register indexes of the color-keyed blit address generator
`default_nettype none

package ckblit_pkg;

  // Screen geometry and color key
  localparam logic [7:0] KEY_COLOR   = 8'hE3;
  localparam logic [8:0] LAST_ROW    = 9'd191;
  localparam int         COL_W       = 17;
  localparam logic [COL_W-1:0] LAST_COLUMN = 17'd255;

  // APB register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef logic [7:0]  pixel_t;
  typedef logic [1:0]  bank_t;
  typedef logic [13:0] offset_t;
  typedef logic [15:0] width_t;
  typedef logic [7:0]  coord_t;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_DEST_X       = 2'd0,
    REG_DEST_Y       = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } reg_idx_t;

  // One result transaction
  typedef struct packed {
    logic    write_enable;
    bank_t   bank_select;
    offset_t bank_offset;
    pixel_t  pixel_out;
    logic    last_pixel;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/ckblit_if.sv @@
// Interfaces: pixel input channel and address result channel
`default_nettype none

interface ckblit_pix_if import ckblit_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ckblit_res_if import ckblit_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    write_enable;
  bank_t   bank_select;
  offset_t bank_offset;
  pixel_t  pixel_out;
  logic    last_pixel;

  modport source (output valid, output write_enable, output bank_select,
                  output bank_offset, output pixel_out, output last_pixel,
                  input ready);
  modport sink   (input valid, input write_enable, input bank_select,
                  input bank_offset, input pixel_out, input last_pixel,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/color_keyed_blit_address_gen.sv @@
// An accepted pixel's result is registered in the output or, on a stall, the skid stage.
// Throughput: one pixel per cycle while the skid stage is empty; the result register
// and a one-entry skid stage let the input take one more pixel after the output stalls.
// The address math is one add and compare between the input port and the result register.
// Reset (rst, synchronous): counters to zero, dest_x/dest_y to 0, width/height to 1,
// result and skid stages empty.
`default_nettype none

module color_keyed_blit_address_gen import ckblit_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  // Streams
  ckblit_pix_if.sink              pixel_stream,
  ckblit_res_if.source            result_stream
);

  // Configuration registers
  coord_t dest_x;
  coord_t dest_y;
  width_t image_width;
  coord_t image_height;

  // Image position counters
  width_t column_count;
  coord_t row_count;
  width_t column_count_next;
  coord_t row_count_next;

  // Output stages
  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;

  reg_idx_t reg_idx;
  logic     cfg_write;
  logic     accept;
  logic     pop;
  result_t  result;

  logic             empty_image;
  logic [8:0]       row;
  logic [COL_W-1:0] col;
  logic             end_col;
  logic             end_row;
  logic             visible;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x       <= '0;
      dest_y       <= '0;
      image_width  <= width_t'(1);
      image_height <= coord_t'(1);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_DEST_X:       dest_x       <= pwdata[7:0];
        REG_DEST_Y:       dest_y       <= pwdata[7:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[15:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DEST_X:       prdata = {24'd0, dest_x};
      REG_DEST_Y:       prdata = {24'd0, dest_y};
      REG_IMAGE_WIDTH:  prdata = {16'd0, image_width};
      REG_IMAGE_HEIGHT: prdata = {24'd0, image_height};
      default:          prdata = '0;
    endcase
  end

  // Handshake: input stalls only once the skid stage is holding a result
  assign pixel_stream.ready = !skid_valid;
  assign accept             = pixel_stream.valid && !skid_valid;
  assign pop                = out_valid && result_stream.ready;

  // Screen position and clipping
  assign empty_image = (image_width == '0) || (image_height == '0);
  assign row     = {1'b0, dest_y} + {1'b0, row_count};
  assign col     = {1'b0, column_count} + {9'd0, dest_x};
  assign end_col = column_count >= (image_width - width_t'(1));
  assign end_row = row_count >= (image_height - coord_t'(1));
  assign visible = !empty_image && ({1'b0, dest_y} <= LAST_ROW) && (row <= LAST_ROW) &&
                   (col <= LAST_COLUMN) && (pixel_stream.pixel_in != KEY_COLOR);

  always_comb begin
    result.write_enable = visible;
    result.bank_select  = visible ? row[7:6] : '0;
    result.bank_offset  = visible ? {row[5:0], col[7:0]} : '0;
    result.pixel_out    = pixel_stream.pixel_in;
    result.last_pixel   = empty_image || (end_col && end_row);
  end

  // Counter update
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (empty_image) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (end_col) begin
      column_count_next = '0;
      row_count_next    = end_row ? '0 : row_count + coord_t'(1);
    end else begin
      column_count_next = column_count + width_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Output register and skid stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output register and skid stage: payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  assign result_stream.valid        = out_valid;
  assign result_stream.write_enable = out_data.write_enable;
  assign result_stream.bank_select  = out_data.bank_select;
  assign result_stream.bank_offset  = out_data.bank_offset;
  assign result_stream.pixel_out    = out_data.pixel_out;
  assign result_stream.last_pixel   = out_data.last_pixel;

endmodule

`default_nettype wire

@@ hdl/ckblit_checker.sv @@
// Checker: assertions on the result port of the blit address generator, with its bind
`default_nettype none

module ckblit_checker import ckblit_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire logic    write_enable,
  input wire bank_t   bank_select,
  input wire offset_t bank_offset,
  input wire pixel_t  pixel_out,
  input wire logic    last_pixel
);

  // A keyed pixel is never written
  a_key_skipped: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> pixel_out != KEY_COLOR)
    else $error("transparent pixel written");

  // A disabled write carries a zero address
  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> bank_select == '0 && bank_offset == '0)
    else $error("address not zero on disabled write");

  // Only three banks exist
  a_bank_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> bank_select != 2'd3)
    else $error("bank select out of range");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_enable) &&
      $stable(bank_select) && $stable(bank_offset) && $stable(pixel_out) &&
      $stable(last_pixel))
    else $error("stalled result changed");

endmodule

bind color_keyed_blit_address_gen ckblit_checker u_ckblit_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_stream.valid),
  .out_ready    (result_stream.ready),
  .write_enable (result_stream.write_enable),
  .bank_select  (result_stream.bank_select),
  .bank_offset  (result_stream.bank_offset),
  .pixel_out    (result_stream.pixel_out),
  .last_pixel   (result_stream.last_pixel)
);

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the color-keyed blit address generator: directed rows, then random images
`timescale 1ns / 100ps

module testbench;
  import ckblit_pkg::*;

  localparam int  RANDOM_ITEMS = 950;
  localparam int  SETTLE_CYCLES = 4;
  localparam int  HOLD_CYCLES = 300;
  localparam int  MAX_SHOWN = 10;

  // One row of the directed stimulus: a register write or a pixel
  typedef struct {
    bit       is_cfg;
    reg_idx_t idx;
    int       value;
    pixel_t   pix;
    bit       typed;
    result_t  res;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ckblit_pix_if pix_if ();
  ckblit_res_if res_if ();

  color_keyed_blit_address_gen u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .pixel_stream  (pix_if),
    .result_stream (res_if)
  );

  // Shadow geometry and image position counters
  int      cfg_dest_x;
  int      cfg_dest_y;
  int      cfg_width;
  int      cfg_height;
  int      col_pos;
  int      row_pos;

  result_t   blit_write_q[$];
  stim_row_t dir_rows[$];
  int        mismatches = 0;
  int        n_results = 0;
  int        n_items = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  bit        hold_go = 1'b0;
  logic      hold_active;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Next screen write for one source pixel; advances the image counters
  function automatic result_t predict_blit_write(pixel_t pix);
    result_t r;
    int      row;
    int      col;
    bit      end_col;
    bit      end_row;
    r = '0;
    r.pixel_out = pix;
    if (cfg_width == 0 || cfg_height == 0) begin
      col_pos = 0;
      row_pos = 0;
      r.last_pixel = 1'b1;
    end else begin
      row = cfg_dest_y + row_pos;
      col = cfg_dest_x + col_pos;
      end_col = (col_pos >= cfg_width - 1);
      end_row = (row_pos >= cfg_height - 1);
      if (cfg_dest_y <= 191 && row <= 191 && col <= 255 && pix != KEY_COLOR) begin
        r.write_enable = 1'b1;
        r.bank_select = bank_t'(row / 64);
        r.bank_offset = offset_t'(((row % 64) << 8) | col);
      end
      if (end_col) begin
        col_pos = 0;
        if (end_row) begin
          row_pos = 0;
          r.last_pixel = 1'b1;
        end else begin
          row_pos = (row_pos + 1) & 8'hFF;
        end
      end else begin
        col_pos = (col_pos + 1) & 16'hFFFF;
      end
    end
    return r;
  endfunction

  function automatic result_t mk_res(bit we, int bank, int off, pixel_t pix, bit last);
    result_t r;
    r.write_enable = we;
    r.bank_select = bank_t'(bank);
    r.bank_offset = offset_t'(off);
    r.pixel_out = pix;
    r.last_pixel = last;
    return r;
  endfunction

  function automatic stim_row_t mk_row(bit is_cfg, reg_idx_t idx, int value, pixel_t pix,
                                       bit typed, result_t res);
    stim_row_t s;
    s.is_cfg = is_cfg;
    s.idx = idx;
    s.value = value;
    s.pix = pix;
    s.typed = typed;
    s.res = res;
    return s;
  endfunction

  // APB write: setup phase, access phase, then the bus is released
  task automatic write_reg(reg_idx_t idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DEST_X:       cfg_dest_x = value & 8'hFF;
      REG_DEST_Y:       cfg_dest_y = value & 8'hFF;
      REG_IMAGE_WIDTH:  cfg_width = value & 16'hFFFF;
      REG_IMAGE_HEIGHT: cfg_height = value & 8'hFF;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering pixels and wait until every expected write has come back
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (blit_write_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one pixel; the expectation is queued at the accepting edge
  task automatic send_pixel(pixel_t pix, bit typed, result_t typed_res);
    result_t pred;
    while ($urandom_range(99) < send_idle) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel_in <= pix;
    do @(posedge clk); while (!pix_if.ready);
    pred = predict_blit_write(pix);
    blit_write_q.push_back(typed ? typed_res : pred);
    n_items++;
  endtask

  // Receiver: random backpressure, long hold-off on request, result check
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.write_enable = res_if.write_enable;
      got.bank_select = res_if.bank_select;
      got.bank_offset = res_if.bank_offset;
      got.pixel_out = res_if.pixel_out;
      got.last_pixel = res_if.last_pixel;
      if (blit_write_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: we=%0b bank=%0d off=%h pix=%h last=%0b",
                   got.write_enable, got.bank_select, got.bank_offset, got.pixel_out,
                   got.last_pixel);
      end else begin
        want = blit_write_q.pop_front();
        if (got.write_enable != want.write_enable || got.bank_select != want.bank_select ||
            got.bank_offset != want.bank_offset || got.pixel_out != want.pixel_out ||
            got.last_pixel != want.last_pixel) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d: exp we=%0b bank=%0d off=%h pix=%h last=%0b, got we=%0b bank=%0d off=%h pix=%h last=%0b",
                     n_results, want.write_enable, want.bank_select, want.bank_offset,
                     want.pixel_out, want.last_pixel, got.write_enable, got.bank_select,
                     got.bank_offset, got.pixel_out, got.last_pixel);
        end
      end
      n_results++;
    end
    if (rst || hold_active)
      res_if.ready <= 1'b0;
    else
      res_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Long receiver hold-off, counted here while the sender keeps going
  initial begin
    hold_active = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Overall time limit
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    int      r;
    int      n;
    int      v;
    bit      wrote;
    int      phase;
    pixel_t  pix;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel_in = '0;
    res_if.ready = 1'b0;
    cfg_dest_x = 0;
    cfg_dest_y = 0;
    cfg_width = 1;
    cfg_height = 1;
    col_pos = 0;
    row_pos = 0;

    // Directed rows; typed results are for one-pixel images and empty images
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h00, 1, mk_res(1, 0, 0, 8'h00, 1)));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'hE3, 1, mk_res(0, 0, 0, 8'hE3, 1)));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'hFF, 1, mk_res(1, 0, 0, 8'hFF, 1)));
    dir_rows.push_back(mk_row(1, REG_DEST_X, 255, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(1, REG_DEST_Y, 191, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h5A, 1, mk_res(1, 2, 16'h3FFF, 8'h5A, 1)));
    // origin row below the screen draws nothing
    dir_rows.push_back(mk_row(1, REG_DEST_Y, 192, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h11, 1, mk_res(0, 0, 0, 8'h11, 1)));
    dir_rows.push_back(mk_row(1, REG_DEST_Y, 255, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h80, 1, mk_res(0, 0, 0, 8'h80, 1)));
    dir_rows.push_back(mk_row(1, REG_DEST_X, 0, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(1, REG_DEST_Y, 64, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h01, 1, mk_res(1, 1, 0, 8'h01, 1)));
    dir_rows.push_back(mk_row(1, REG_DEST_Y, 128, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h02, 1, mk_res(1, 2, 0, 8'h02, 1)));
    // empty image: zero width, then zero height
    dir_rows.push_back(mk_row(1, REG_IMAGE_WIDTH, 0, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h33, 1, mk_res(0, 0, 0, 8'h33, 1)));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'hE3, 1, mk_res(0, 0, 0, 8'hE3, 1)));
    dir_rows.push_back(mk_row(1, REG_IMAGE_WIDTH, 3, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(1, REG_IMAGE_HEIGHT, 0, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h44, 1, mk_res(0, 0, 0, 8'h44, 1)));
    // 3x2 image straddling the right edge and the last row
    dir_rows.push_back(mk_row(1, REG_IMAGE_HEIGHT, 2, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(1, REG_DEST_X, 254, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(1, REG_DEST_Y, 190, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h10, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'hE3, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h20, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h30, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h40, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h50, 0, '0));
    // widest and tallest image, then shrink the width mid-row
    dir_rows.push_back(mk_row(1, REG_IMAGE_WIDTH, 65535, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(1, REG_IMAGE_HEIGHT, 255, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(1, REG_DEST_X, 0, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(1, REG_DEST_Y, 0, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'hA5, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h5A, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'hC3, 0, '0));
    dir_rows.push_back(mk_row(1, REG_IMAGE_WIDTH, 2, 8'h00, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h7F, 0, '0));
    dir_rows.push_back(mk_row(0, REG_DEST_X, 0, 8'h81, 0, '0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first phase: sender rarely idles, receiver often stalls
    send_idle = 6;
    recv_idle = 69;
    phase = 1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random images: new geometry between images, mostly small ones
    while (n_items < RANDOM_ITEMS + 22) begin
      wait_idle();
      wrote = 1'b0;
      if ($urandom_range(1)) begin
        r = $urandom_range(99);
        if (r < 20) v = 0;
        else if (r < 40) v = 255;
        else if (r < 50) v = $urandom_range(254, 240);
        else v = $urandom_range(255);
        write_reg(REG_DEST_X, v);
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        r = $urandom_range(99);
        if (r < 15) v = 0;
        else if (r < 30) v = 191;
        else if (r < 40) v = $urandom_range(255, 192);
        else if (r < 50) v = $urandom_range(190, 180);
        else v = $urandom_range(191);
        write_reg(REG_DEST_Y, v);
        wrote = 1'b1;
      end
      if ($urandom_range(1) || !wrote) begin
        r = $urandom_range(99);
        if (r < 5) v = 0;
        else if (r < 10) v = 65535;
        else if (r < 20) v = $urandom_range(300, 17);
        else v = $urandom_range(16, 1);
        write_reg(REG_IMAGE_WIDTH, v);
      end
      if ($urandom_range(1)) begin
        r = $urandom_range(99);
        if (r < 5) v = 0;
        else if (r < 10) v = 255;
        else if (r < 20) v = $urandom_range(254, 7);
        else v = $urandom_range(6, 1);
        write_reg(REG_IMAGE_HEIGHT, v);
      end

      // whole image mostly; large or occasional images are cut short
      if (cfg_width == 0 || cfg_height == 0) begin
        n = $urandom_range(4, 1);
      end else begin
        n = cfg_width * cfg_height;
        if (n > 64 || $urandom_range(9) == 0)
          n = $urandom_range((n > 64) ? 64 : n, 1);
      end

      if (phase == 1 && n_items >= 330) begin
        send_idle = 69;
        recv_idle = 6;
        phase = 2;
      end else if (phase == 2 && n_items >= 640) begin
        send_idle = 0;
        recv_idle = 0;
        phase = 3;
        hold_go = 1'b1;
        n = 40;
      end

      repeat (n) begin
        pix = ($urandom_range(4) == 0) ? KEY_COLOR : pixel_t'($urandom_range(255));
        send_pixel(pix, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && blit_write_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
